// File: rtl/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/tsde_pkg.sv
package tsde_pkg;

  localparam int unsigned CNT_W = 5;
  localparam int unsigned NUM_CHAN = 3;
  localparam logic [CNT_W-1:0] DEBOUNCE_RESET = CNT_W'(20);

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_ALL       = 3'd1,
    EV_LEFT_ON   = 3'd2,
    EV_LEFT_OFF  = 3'd3,
    EV_MID_ON    = 3'd4,
    EV_MID_OFF   = 3'd5,
    EV_RIGHT_ON  = 3'd6,
    EV_RIGHT_OFF = 3'd7
  } event_t;

  // per-sample control from the top level to each channel
  typedef struct packed {
    logic step;   // a sample is processed this cycle
    logic first;  // it is the first sample after reset
  } chan_ctl_t;

endpackage

// File: rtl/tsde_chan.sv
module tsde_chan
  import tsde_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  chan_ctl_t        ctl,
  input  logic             raw,
  input  logic [CNT_W-1:0] debounce_count,
  output logic             stable,
  output logic             stable_next
);

  logic             prev_raw;
  logic             prev_raw_next;
  logic [CNT_W-1:0] run_length;
  logic [CNT_W-1:0] run_length_next;

  always_comb begin
    prev_raw_next   = prev_raw;
    run_length_next = run_length;
    stable_next     = stable;
    if (ctl.step) begin
      if (ctl.first) begin
        prev_raw_next   = raw;
        run_length_next = '0;
        stable_next     = raw;
      end else begin
        prev_raw_next = raw;
        if (raw == prev_raw) begin
          // saturate at the threshold
          if (run_length < debounce_count) begin
            run_length_next = run_length + CNT_W'(1);
          end
        end else begin
          run_length_next = CNT_W'(1);
        end
        if (run_length_next >= debounce_count) begin
          stable_next = raw;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_raw   <= 1'b0;
      run_length <= '0;
      stable     <= 1'b0;
    end else begin
      prev_raw   <= prev_raw_next;
      run_length <= run_length_next;
      stable     <= stable_next;
    end
  end

endmodule

// File: rtl/tape_sensor_debounce_events.sv
// channel   | dir | handshake          | payload
// ----------+-----+--------------------+------------------------------------
// sample    | in  | in_valid/in_stall  | left_raw, middle_raw, right_raw
// event     | out | out_valid/out_stall| event_code, stable_bits
// config    | in  | cfg_wr_en          | cfg_wr_data (debounce_count)
//
// one sample per cycle while no held result is stalled: a sample is captured
// in the input register, then debounced and encoded in a single pass into
// the result register
// rst is synchronous: debounce count returns to 20, all channel state clears
// a stalled result holds the pass stage; the input register still takes one
// more sample, so the input side stalls only when both registers are full
module tape_sensor_debounce_events
  import tsde_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             left_raw,
  input  logic             middle_raw,
  input  logic             right_raw,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       event_code,
  output logic [2:0]       stable_bits,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data
);

`include "assert_macros.svh"

  // configuration
  logic [CNT_W-1:0] debounce_count;

  // input register
  logic                s1_valid;
  logic [NUM_CHAN-1:0] s1_raw;

  // pass control
  logic      started;
  logic      out_free;
  logic      process;
  chan_ctl_t ctl;

  // debounced state, current and after this pass
  logic [NUM_CHAN-1:0] stable_now;
  logic [NUM_CHAN-1:0] stable_new;
  logic [NUM_CHAN-1:0] diff;
  logic                emit;
  event_t              code;

  // result register is free when empty or being drained this cycle
  assign out_free = !out_valid || !out_stall;
  assign process  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  assign ctl.step  = process;
  assign ctl.first = !started;

  tsde_chan u_left (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .raw            (s1_raw[0]),
    .debounce_count (debounce_count),
    .stable         (stable_now[0]),
    .stable_next    (stable_new[0])
  );

  tsde_chan u_middle (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .raw            (s1_raw[1]),
    .debounce_count (debounce_count),
    .stable         (stable_now[1]),
    .stable_next    (stable_new[1])
  );

  tsde_chan u_right (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .raw            (s1_raw[2]),
    .debounce_count (debounce_count),
    .stable         (stable_now[2]),
    .stable_next    (stable_new[2])
  );

  // the reported state always equals the stable state, so any change
  // of the packed stable bits makes exactly one event
  assign diff = stable_new ^ stable_now;
  assign emit = process && started && (diff != '0);

  // event priority: none seen, all seen, then left, middle, right
  always_comb begin
    if (stable_new == 3'b000) begin
      code = EV_NONE;
    end else if (stable_new == 3'b111) begin
      code = EV_ALL;
    end else if (diff[0]) begin
      code = stable_new[0] ? EV_LEFT_ON : EV_LEFT_OFF;
    end else if (diff[1]) begin
      code = stable_new[1] ? EV_MID_ON : EV_MID_OFF;
    end else begin
      code = stable_new[2] ? EV_RIGHT_ON : EV_RIGHT_OFF;
    end
  end

  // debounce threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_count <= DEBOUNCE_RESET;
    end else if (cfg_wr_en) begin
      debounce_count <= cfg_wr_data;
    end
  end

  // input register: takes a sample whenever it is empty or being consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (process) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_raw <= {right_raw, middle_raw, left_raw};
    end
  end

  // first processed sample only loads the channels
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
    end else if (process) begin
      started <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      event_code  <= code;
      stable_bits <= stable_new;
    end
  end

  // a waiting result always matches the channels' stable state
  `ASSERT_IMPLIES(a_result_matches_state, clk, rst, out_valid, stable_bits == stable_now)

  // nothing is reported before the first sample loads the channels
  `ASSERT_IMPLIES(a_no_event_before_start, clk, rst, !started, !out_valid)

  // the loading sample emits nothing
  `ASSERT_NEXT(a_load_is_silent, clk, rst, process && !started, started && !out_valid)

  // "none seen" is reported exactly when the new state is all clear
  `ASSERT_IMPLIES(a_none_code, clk, rst, out_valid, (stable_bits == 3'b000) == (event_code == EV_NONE))

endmodule

// File: tb/sv/tb_tape_sensor_debounce_events.sv
module tb_tape_sensor_debounce_events;
  import tsde_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // long receiver hold-off, in cycles, used once to back the block up
  localparam int HOLD_CYCLES = 80;
  // cap on printed mismatch lines, the count keeps going
  localparam int MAX_LINES = 40;

  typedef struct {
    event_t     code;
    logic [2:0] bits;
  } tape_event_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             left_raw = 1'b0;
  logic             middle_raw = 1'b0;
  logic             right_raw = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [2:0]       event_code;
  logic [2:0]       stable_bits;
  logic             cfg_wr_en = 1'b0;
  logic [CNT_W-1:0] cfg_wr_data = '0;

  // samples waiting to be offered, packed {right, middle, left}
  logic [2:0]  samples_todo[$];
  // events the debouncer is expected to emit, oldest first
  tape_event_t events_due[$];

  // shadow of the debouncer state
  logic [CNT_W-1:0] thresh = DEBOUNCE_RESET;
  logic             started;
  logic [2:0]       last_raw;
  logic [CNT_W-1:0] run_len[NUM_CHAN];
  logic [2:0]       stable;
  logic [2:0]       reported;

  int  errors = 0;
  logic in_xfer = 1'b0;
  int  src_idle_pct = 32;
  int  snk_idle_pct = 32;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int  hold_left = 0;

  tape_sensor_debounce_events dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .left_raw    (left_raw),
    .middle_raw  (middle_raw),
    .right_raw   (right_raw),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_code  (event_code),
    .stable_bits (stable_bits),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (errors < MAX_LINES) $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // one accepted sample through the debouncer, queues the event it causes
  task automatic debounce_sample(input logic [2:0] raw);
    logic [2:0]  diff;
    tape_event_t ev;
    if (!started) begin
      // first sample after reset loads everything and stays silent
      stable = raw;
      last_raw = raw;
      foreach (run_len[c]) run_len[c] = '0;
      reported = raw;
      started = 1'b1;
      return;
    end
    for (int c = 0; c < NUM_CHAN; c++) begin
      if (raw[c] == last_raw[c]) begin
        // run counter saturates at the threshold
        if (run_len[c] < thresh) run_len[c] = run_len[c] + 1'b1;
      end else begin
        last_raw[c] = raw[c];
        run_len[c] = 1;
      end
      if (run_len[c] >= thresh) stable[c] = raw[c];
    end
    if (stable == reported) return;
    diff = stable ^ reported;
    // whole-state codes win, then the lowest changed channel
    if (stable == 3'b000) ev.code = EV_NONE;
    else if (stable == 3'b111) ev.code = EV_ALL;
    else if (diff[0]) ev.code = stable[0] ? EV_LEFT_ON : EV_LEFT_OFF;
    else if (diff[1]) ev.code = stable[1] ? EV_MID_ON : EV_MID_OFF;
    else ev.code = stable[2] ? EV_RIGHT_ON : EV_RIGHT_OFF;
    ev.bits = stable;
    reported = stable;
    events_due.push_back(ev);
  endtask

  // monitor: sample transfers feed the shadow, event transfers are checked
  always @(posedge clk) begin
    if (rst) begin
      in_xfer <= 1'b0;
      started = 1'b0;
      last_raw = '0;
      foreach (run_len[c]) run_len[c] = '0;
      stable = '0;
      reported = '0;
    end else begin
      in_xfer <= in_valid && !in_stall;
      if (in_valid && !in_stall) debounce_sample({right_raw, middle_raw, left_raw});
      if (out_valid === 1'b1 && !out_stall) begin
        if (events_due.size() == 0) begin
          report_mismatch($sformatf("unexpected event code %0d bits %b",
                                    event_code, stable_bits));
        end else begin
          tape_event_t want;
          want = events_due.pop_front();
          if (event_code !== want.code)
            report_mismatch($sformatf("event_code %0d, want %0d (%s)",
                                      event_code, want.code, want.code.name()));
          if (stable_bits !== want.bits)
            report_mismatch($sformatf("stable_bits %b, want %b", stable_bits, want.bits));
        end
      end
    end
  end

  // sender: offers queued samples, holds the payload while stalled
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_xfer) begin
      if (samples_todo.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        {right_raw, middle_raw, left_raw} <= samples_todo.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off when asked
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < snk_idle_pct);
    end
  end

  // register write, only called with the block idle
  task automatic set_debounce(input logic [CNT_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    thresh = value;
  endtask

  // wait for every sample taken and every event seen, then let the pipe settle
  task automatic drain();
    while (samples_todo.size() != 0 || in_valid || events_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // per-channel runs around the threshold length, with glitches and noise
  task automatic queue_runs(input int n);
    logic [2:0] level;
    logic [2:0] s;
    int         left_run[NUM_CHAN];
    int         span;
    int         pick;
    level = 3'($urandom_range(7));
    span = (thresh == 0) ? 1 : int'(thresh);
    foreach (left_run[c]) left_run[c] = $urandom_range(1, 2 * span + 2);
    for (int k = 0; k < n; k++) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        if (left_run[c] == 0) begin
          level[c] = 1'($urandom_range(1));
          left_run[c] = $urandom_range(1, 2 * span + 2);
        end
        left_run[c]--;
      end
      s = level;
      pick = $urandom_range(99);
      if (pick < 5) s = 3'($urandom_range(7));
      else if (pick < 13) s[$urandom_range(2)] ^= 1'b1;
      samples_todo.push_back(s);
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // first sample only loads the stable state, then runs at the reset count
    samples_todo.push_back(3'b101);
    queue_runs(90);
    drain();

    // count of one walks every event code
    set_debounce(1);
    samples_todo = '{3'b000, 3'b111, 3'b000, 3'b001, 3'b011, 3'b111, 3'b110, 3'b100,
                     3'b101, 3'b001, 3'b011, 3'b010, 3'b110, 3'b100, 3'b000};
    drain();

    // count of zero follows the raw value at once
    set_debounce(0);
    samples_todo = '{3'b111, 3'b000, 3'b010};
    queue_runs(40);
    drain();

    // top count, runs long enough to saturate
    set_debounce(31);
    queue_runs(100);
    drain();

    // count of one with a long receiver hold-off so the input stalls
    set_debounce(1);
    hold_go = 1'b1;
    queue_runs(60);
    drain();

    set_debounce(3);
    queue_runs(80);
    drain();

    // stretch with no idling on either side
    src_idle_pct = 0;
    snk_idle_pct = 0;
    set_debounce(8);
    queue_runs(80);
    drain();
    src_idle_pct = 32;
    snk_idle_pct = 32;

    set_debounce(CNT_W'($urandom_range(1, 31)));
    queue_runs(60);
    drain();

    set_debounce(DEBOUNCE_RESET);
    queue_runs(40);
    drain();

    if (events_due.size() != 0)
      report_mismatch($sformatf("%0d events never arrived", events_due.size()));
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

endmodule
